@@ sv/cfc_pkg.sv @@
// ----------------------------------------------------------------------------
// cfc_pkg
// Shared types and constants for the command frame collector: register
// indexes, reset values, frame kinds and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package cfc_pkg;

  // Default frame buffer depth in bytes
  localparam int BUFFER_DEPTH_DEFAULT = 64;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_SET_CODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GET_CODE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SET_ONCE_CODE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PARAM_LEN = 2'd3;

  localparam logic [7:0] SET_CODE_RST      = 8'd192;
  localparam logic [7:0] GET_CODE_RST      = 8'd193;
  localparam logic [7:0] SET_ONCE_CODE_RST = 8'd194;
  localparam logic [5:0] MAX_PARAM_LEN_RST = 6'd60;

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int INDEX_W = 6;
  localparam int KIND_W  = 2;
  localparam int PLEN_W  = 6;

  // Frame kinds
  localparam logic [KIND_W-1:0] KIND_SET      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GET      = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SET_ONCE = 2'd2;

  // Frame layout: a get frame has three bytes, the length byte is the third
  localparam int GET_FRAME_LEN = 3;
  localparam int LEN_BYTE_POS  = 3;

  // Controller to datapath
  typedef struct packed {
    logic in_take;   // input transaction completes this cycle
    logic rd_en;     // read the next frame byte from the buffer
    logic out_take;  // output transaction completes this cycle
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic emit;      // the byte being taken completes a frame
    logic last;      // byte on display is the final one of the frame
  } status_t;

endpackage

@@ sv/cfc_ctrl.sv @@
// ----------------------------------------------------------------------------
// cfc_ctrl
// Controller: sequences byte collection and frame emission and drives the
// handshake of both channels.
// ----------------------------------------------------------------------------
module cfc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  cfc_pkg::status_t status,
  output cfc_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_COLLECT = 3'b001,
    S_READ    = 3'b010,
    S_SHOW    = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Handshake and commands
  assign in_stall     = (state_r != S_COLLECT);
  assign out_valid    = (state_r == S_SHOW);
  assign cmd.in_take  = in_valid && (state_r == S_COLLECT);
  assign cmd.rd_en    = (state_r == S_READ);
  assign cmd.out_take = (state_r == S_SHOW) && !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_COLLECT: begin
        if (cmd.in_take && status.emit) state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = S_SHOW;
      end
      S_SHOW: begin
        if (!out_stall) state_nxt = status.last ? S_COLLECT : S_READ;
      end
      default: begin
        state_nxt = S_COLLECT;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_COLLECT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ sv/cfc_datapath.sv @@
// ----------------------------------------------------------------------------
// cfc_datapath
// Datapath: configuration registers, frame parser counters, frame buffer
// and the output register of the result channel.
// ----------------------------------------------------------------------------
module cfc_datapath #(
  parameter int BUFFER_DEPTH = cfc_pkg::BUFFER_DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cfc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cfc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic [cfc_pkg::BYTE_W-1:0]        in_rx_byte,
  input  cfc_pkg::cmd_t                     cmd,
  output cfc_pkg::status_t                  status,
  output logic [cfc_pkg::BYTE_W-1:0]        out_frame_byte,
  output logic [cfc_pkg::INDEX_W-1:0]       out_byte_index,
  output logic [cfc_pkg::KIND_W-1:0]        out_frame_kind,
  output logic                              out_last_byte
);

  localparam int AW  = $clog2(BUFFER_DEPTH);
  localparam int CW  = $clog2(BUFFER_DEPTH + 1);
  localparam int SUM_W = 10;

  // Configuration registers
  logic [7:0] set_code_r, get_code_r, set_once_code_r;
  logic [cfc_pkg::PLEN_W-1:0] max_plen_r;

  // Parser state
  logic                          collecting_r;
  logic [cfc_pkg::KIND_W-1:0]    kind_r;
  logic [CW-1:0]                 count_r;
  logic [cfc_pkg::PLEN_W-1:0]    plen_r;

  // Emission
  logic [AW-1:0]                 rd_idx_r;
  logic [cfc_pkg::BYTE_W-1:0]    rd_data_r;
  logic                          last_r;

  // Frame buffer
  logic [cfc_pkg::BYTE_W-1:0]    mem [BUFFER_DEPTH];

  // Parse decisions for the byte being taken
  logic                          hdr_hit;
  logic [cfc_pkg::KIND_W-1:0]    hdr_kind;
  logic [CW-1:0]                 cnt_inc;
  logic                          at_len_byte;
  logic                          too_big;
  logic                          done;
  logic                          full;
  logic                          drop;
  logic [SUM_W-1:0]              plen_sum;
  logic [AW-1:0]                 wr_addr;
  logic                          wr_en;

  // Match a header, set first, then get, then set once
  always_comb begin
    hdr_hit  = 1'b1;
    hdr_kind = cfc_pkg::KIND_SET;
    if (in_rx_byte == set_code_r) begin
      hdr_kind = cfc_pkg::KIND_SET;
    end else if (in_rx_byte == get_code_r) begin
      hdr_kind = cfc_pkg::KIND_GET;
    end else if (in_rx_byte == set_once_code_r) begin
      hdr_kind = cfc_pkg::KIND_SET_ONCE;
    end else begin
      hdr_hit = 1'b0;
    end
  end

  // Decide completion and drop for a byte inside a frame
  assign cnt_inc     = count_r + CW'(1);
  assign at_len_byte = (cnt_inc == CW'(cfc_pkg::LEN_BYTE_POS));
  assign too_big     = in_rx_byte > {2'b00, max_plen_r};
  assign plen_sum    = SUM_W'(plen_r) + SUM_W'(cfc_pkg::LEN_BYTE_POS);
  assign full        = (SUM_W'(cnt_inc) >= SUM_W'(BUFFER_DEPTH));

  always_comb begin
    if (kind_r == cfc_pkg::KIND_GET) begin
      done = (cnt_inc == CW'(cfc_pkg::GET_FRAME_LEN));
    end else if (at_len_byte) begin
      done = (in_rx_byte == '0);
    end else begin
      done = (plen_sum == SUM_W'(cnt_inc));
    end
  end

  assign drop = full || ((kind_r != cfc_pkg::KIND_GET) && at_len_byte && too_big);

  assign status.emit = collecting_r && done && !drop;
  assign status.last = last_r;

  // Buffer write: header at entry 0, later bytes at the running count
  assign wr_en   = cmd.in_take && (collecting_r || hdr_hit);
  assign wr_addr = collecting_r ? count_r[AW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_rx_byte;
    end
  end

  // Read one buffered byte into the output register
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_idx_r];
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_code_r      <= cfc_pkg::SET_CODE_RST;
      get_code_r      <= cfc_pkg::GET_CODE_RST;
      set_once_code_r <= cfc_pkg::SET_ONCE_CODE_RST;
      max_plen_r      <= cfc_pkg::MAX_PARAM_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cfc_pkg::REG_SET_CODE:      set_code_r      <= cfg_wdata;
        cfc_pkg::REG_GET_CODE:      get_code_r      <= cfg_wdata;
        cfc_pkg::REG_SET_ONCE_CODE: set_once_code_r <= cfg_wdata;
        cfc_pkg::REG_MAX_PARAM_LEN: max_plen_r      <= cfg_wdata[cfc_pkg::PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Parser and emission counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      collecting_r <= 1'b0;
      kind_r       <= cfc_pkg::KIND_SET;
      count_r      <= '0;
      plen_r       <= '0;
      rd_idx_r     <= '0;
      last_r       <= 1'b0;
    end else begin
      if (cmd.in_take) begin
        if (!collecting_r) begin
          // open a frame on a header, ignore anything else
          if (hdr_hit) begin
            collecting_r <= 1'b1;
            kind_r       <= hdr_kind;
            count_r      <= CW'(1);
          end
        end else if (drop) begin
          collecting_r <= 1'b0;
          count_r      <= '0;
          plen_r       <= '0;
        end else begin
          count_r <= cnt_inc;
          if ((kind_r != cfc_pkg::KIND_GET) && at_len_byte) begin
            plen_r <= in_rx_byte[cfc_pkg::PLEN_W-1:0];
          end
          if (done) begin
            rd_idx_r <= '0;
          end
        end
      end
      if (cmd.rd_en) begin
        last_r <= (CW'(rd_idx_r) + CW'(1) == count_r);
      end
      if (cmd.out_take) begin
        if (last_r) begin
          // frame delivered: back to idle
          collecting_r <= 1'b0;
          count_r      <= '0;
          plen_r       <= '0;
        end else begin
          rd_idx_r <= rd_idx_r + AW'(1);
        end
      end
    end
  end

  // Result fields
  assign out_frame_byte = rd_data_r;
  assign out_byte_index = cfc_pkg::INDEX_W'(rd_idx_r);
  assign out_frame_kind = kind_r;
  assign out_last_byte  = last_r;

  // A read only happens inside a collected frame
  a_read_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> collecting_r)
    else $error("buffer read outside a frame");

  // The count never reaches the buffer depth while collecting
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    collecting_r |-> (SUM_W'(count_r) < SUM_W'(BUFFER_DEPTH)))
    else $error("frame count reached buffer depth");

  // An emitted frame starts at index zero on the next read
  a_emit_start: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.in_take && status.emit) |=> (rd_idx_r == '0) && cmd.rd_en)
    else $error("emission did not start at the header");

endmodule

@@ sv/command_frame_collector.sv @@
// ----------------------------------------------------------------------------
// command_frame_collector
// Collects received serial bytes into set, get and set-once command frames
// and replays each complete frame byte by byte with a last-byte mark.
// ----------------------------------------------------------------------------
// While no frame is being emitted the block takes one byte per cycle: header
// matching, length checks and the buffer write all finish in the cycle the
// byte is taken. Once a byte completes a frame, input is stalled and the
// frame is replayed from the buffer byte by byte, each byte passing through a
// buffer read state and then a display state in the output register, where it
// stays while the receiver stalls, and input stays held until the last byte.
// Invalid headers are ignored, and frames with an oversize length or that
// fill the buffer are dropped without output.
module command_frame_collector #(
  parameter int BUFFER_DEPTH = cfc_pkg::BUFFER_DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [cfc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cfc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // received bytes
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [cfc_pkg::BYTE_W-1:0]        in_rx_byte,
  // frame bytes
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [cfc_pkg::BYTE_W-1:0]        out_frame_byte,
  output logic [cfc_pkg::INDEX_W-1:0]       out_byte_index,
  output logic [cfc_pkg::KIND_W-1:0]        out_frame_kind,
  output logic                              out_last_byte
);

  cfc_pkg::cmd_t    cmd;
  cfc_pkg::status_t status;

  cfc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  cfc_datapath #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_rx_byte     (in_rx_byte),
    .cmd            (cmd),
    .status         (status),
    .out_frame_byte (out_frame_byte),
    .out_byte_index (out_byte_index),
    .out_frame_kind (out_frame_kind),
    .out_last_byte  (out_last_byte)
  );

  // Input is held off while a frame is on display
  a_no_input_during_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open during frame emission");

  // After the last byte goes out, input opens again
  a_reopen_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_byte) |=> !in_stall && !out_valid)
    else $error("input not reopened after frame end");

  // Consecutive bytes of a frame carry consecutive indexes
  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_byte) |=> ##1
      (out_valid && (out_byte_index == $past(out_byte_index, 2) + 6'd1)))
    else $error("frame byte index did not advance by one");

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the command frame collector: drives received
// bytes, predicts the replayed frame bytes and compares every result.
// ----------------------------------------------------------------------------
// A short directed pass covers ignored bytes, each frame kind, the zero and
// the oversize length and equal header codes. Random traffic follows in four
// phases with their own register settings and idle/stall mix. The predictor
// tracks the frame being collected and queues the expected frame bytes, and
// a monitor checks each output transaction against the oldest entry.
// With limits of at most 60 as used here a frame never reaches the 64-byte
// buffer, so the buffer-full drop is kept in the predictor but not provoked.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DEPTH        = cfc_pkg::BUFFER_DEPTH_DEFAULT;
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_ITEMS   = 95;

  typedef struct packed {
    logic [cfc_pkg::BYTE_W-1:0]  frame_byte;
    logic [cfc_pkg::INDEX_W-1:0] byte_index;
    logic [cfc_pkg::KIND_W-1:0]  frame_kind;
    logic                        last_byte;
  } frame_beat_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [cfc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [cfc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [cfc_pkg::BYTE_W-1:0]     in_rx_byte = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [cfc_pkg::BYTE_W-1:0]     out_frame_byte;
  logic [cfc_pkg::INDEX_W-1:0]    out_byte_index;
  logic [cfc_pkg::KIND_W-1:0]     out_frame_kind;
  logic                           out_last_byte;

  // Register copies held by the predictor
  logic [7:0]                 pred_set_code  = cfc_pkg::SET_CODE_RST;
  logic [7:0]                 pred_get_code  = cfc_pkg::GET_CODE_RST;
  logic [7:0]                 pred_once_code = cfc_pkg::SET_ONCE_CODE_RST;
  logic [cfc_pkg::PLEN_W-1:0] pred_max_len   = cfc_pkg::MAX_PARAM_LEN_RST;

  // Frame collection state of the predictor
  bit                         collecting = 1'b0;
  logic [cfc_pkg::KIND_W-1:0] held_kind  = cfc_pkg::KIND_SET;
  int                         rx_count   = 0;
  int                         param_len  = 0;
  logic [7:0]                 frame_buf [DEPTH];

  frame_beat_t pending_frame_bytes [$];
  int          error_count = 0;
  int          items_sent  = 0;
  int          idle_pct    = 0;
  int          stall_pct   = 0;

  command_frame_collector u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_byte (out_frame_byte),
    .out_byte_index (out_byte_index),
    .out_frame_kind (out_frame_kind),
    .out_last_byte  (out_last_byte)
  );

  always #5 clk = ~clk;

  // Stall the result channel at the phase's rate
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Abort a hung run
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // Return to idle; the frame kind is held
  task automatic close_frame();
    collecting = 1'b0;
    rx_count   = 0;
    param_len  = 0;
  endtask

  // Advance the frame collector by one received byte, queue any frame bytes
  task automatic collect_rx_byte(input logic [7:0] b);
    bit          done;
    int          i;
    frame_beat_t beat;
    done = 1'b0;
    if (!collecting) begin
      if (b == pred_set_code) held_kind = cfc_pkg::KIND_SET;
      else if (b == pred_get_code) held_kind = cfc_pkg::KIND_GET;
      else if (b == pred_once_code) held_kind = cfc_pkg::KIND_SET_ONCE;
      else return;
      collecting   = 1'b1;
      frame_buf[0] = b;
      rx_count     = 1;
      return;
    end
    if (rx_count < DEPTH) frame_buf[rx_count] = b;
    rx_count++;
    if (held_kind == cfc_pkg::KIND_GET) begin
      done = (rx_count == cfc_pkg::GET_FRAME_LEN);
    end else if (rx_count == cfc_pkg::LEN_BYTE_POS) begin
      param_len = b;
      if (param_len > pred_max_len) begin
        close_frame();
        return;
      end
      done = (param_len == 0);
    end else begin
      done = (param_len + cfc_pkg::LEN_BYTE_POS == rx_count);
    end
    if (rx_count >= DEPTH) begin
      close_frame();
      return;
    end
    if (done) begin
      for (i = 0; i < rx_count; i++) begin
        beat.frame_byte = frame_buf[i];
        beat.byte_index = i[cfc_pkg::INDEX_W-1:0];
        beat.frame_kind = held_kind;
        beat.last_byte  = (i + 1 == rx_count);
        pending_frame_bytes.push_back(beat);
      end
      close_frame();
    end
  endtask

  // Drive one byte, hold it until the transaction completes
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
    collect_rx_byte(b);
  endtask

  task automatic send_frame3(input logic [7:0] b0, input logic [7:0] b1,
                             input logic [7:0] b2);
    send_byte(b0);
    send_byte(b1);
    send_byte(b2);
  endtask

  // Drop valid, wait for every frame byte, then let the block settle
  task automatic wait_frames_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_frame_bytes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write all four registers; call only while the block is idle
  task automatic write_codes(input logic [7:0] set_c, input logic [7:0] get_c,
                             input logic [7:0] once_c,
                             input logic [cfc_pkg::PLEN_W-1:0] max_len);
    logic [cfc_pkg::CFG_DATA_W-1:0] val [4];
    logic [cfc_pkg::CFG_IDX_W-1:0]  idx [4];
    int i;
    idx[0] = cfc_pkg::REG_SET_CODE;      val[0] = set_c;
    idx[1] = cfc_pkg::REG_GET_CODE;      val[1] = get_c;
    idx[2] = cfc_pkg::REG_SET_ONCE_CODE; val[2] = once_c;
    idx[3] = cfc_pkg::REG_MAX_PARAM_LEN; val[3] = cfc_pkg::CFG_DATA_W'(max_len);
    for (i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    pred_set_code  = set_c;
    pred_get_code  = get_c;
    pred_once_code = once_c;
    pred_max_len   = max_len;
  endtask

  task automatic draw_codes(output logic [7:0] set_c, output logic [7:0] get_c,
                            output logic [7:0] once_c);
    set_c = 8'($urandom_range(255));
    do get_c = 8'($urandom_range(255)); while (get_c == set_c);
    do once_c = 8'($urandom_range(255)); while (once_c == set_c || once_c == get_c);
  endtask

  // Compare each output transaction with the oldest expected frame byte
  always @(posedge clk) begin
    frame_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_frame_bytes.size() == 0) begin
        $error("unexpected frame byte %0d at index %0d", out_frame_byte, out_byte_index);
        error_count++;
      end else begin
        want = pending_frame_bytes.pop_front();
        if (out_frame_byte !== want.frame_byte) begin
          $error("frame_byte: expected %0d, got %0d", want.frame_byte, out_frame_byte);
          error_count++;
        end
        if (out_byte_index !== want.byte_index) begin
          $error("byte_index: expected %0d, got %0d", want.byte_index, out_byte_index);
          error_count++;
        end
        if (out_frame_kind !== want.frame_kind) begin
          $error("frame_kind: expected %0d, got %0d", want.frame_kind, out_frame_kind);
          error_count++;
        end
        if (out_last_byte !== want.last_byte) begin
          $error("last_byte: expected %0d, got %0d", want.last_byte, out_last_byte);
          error_count++;
        end
      end
    end
  end

  // Ignored bytes and one frame of each kind at the reset codes
  task automatic test_reset_defaults();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame3(cfc_pkg::GET_CODE_RST, 8'hFF, 8'h00);
    send_frame3(cfc_pkg::SET_CODE_RST, 8'hA5, 8'd0);
    send_frame3(cfc_pkg::SET_ONCE_CODE_RST, 8'h5A, 8'd2);
    send_byte(8'h01);
    send_byte(8'hFE);
    wait_frames_drained();
  endtask

  // Oversize lengths drop the frame; a zero limit still passes zero length
  task automatic test_length_limit();
    send_frame3(cfc_pkg::SET_CODE_RST, 8'h11, 8'(cfc_pkg::MAX_PARAM_LEN_RST) + 8'd1);
    send_frame3(cfc_pkg::SET_ONCE_CODE_RST, 8'h00, 8'hFF);
    wait_frames_drained();
    write_codes(cfc_pkg::SET_CODE_RST, cfc_pkg::GET_CODE_RST, cfc_pkg::SET_ONCE_CODE_RST,
                '0);
    send_frame3(cfc_pkg::SET_CODE_RST, 8'h00, 8'd1);
    send_frame3(cfc_pkg::SET_CODE_RST, 8'h00, 8'd0);
    wait_frames_drained();
  endtask

  // Equal header codes: set beats get, get beats set once
  task automatic test_equal_codes();
    write_codes(8'h5A, 8'h5A, 8'h5A, cfc_pkg::MAX_PARAM_LEN_RST);
    send_frame3(8'h5A, 8'h07, 8'd0);
    wait_frames_drained();
    write_codes(8'h00, 8'h5A, 8'h5A, cfc_pkg::MAX_PARAM_LEN_RST);
    send_frame3(8'h5A, 8'h01, 8'd2);
    wait_frames_drained();
  endtask

  // One random frame: mostly well formed, some noise and oversize lengths
  task automatic send_random_frame();
    int         pick;
    int         kind_pick;
    int         len;
    int         i;
    logic [7:0] noise;
    pick = $urandom_range(99);
    if (pick < 10) begin
      // noise never opens a frame, so the collector stays idle between frames
      do noise = 8'($urandom_range(255));
      while (noise == pred_set_code || noise == pred_get_code || noise == pred_once_code);
      send_byte(noise);
      return;
    end
    kind_pick = $urandom_range(2);
    case (kind_pick)
      0: send_byte(pred_set_code);
      1: send_byte(pred_get_code);
      default: send_byte(pred_once_code);
    endcase
    send_byte(8'($urandom_range(255)));
    if (kind_pick == 1) begin
      send_byte(8'($urandom_range(255)));
      return;
    end
    pick = $urandom_range(99);
    if (pick < 8 && pred_max_len < 255) len = $urandom_range(255, int'(pred_max_len) + 1);
    else if (pick < 14) len = pred_max_len;
    else len = $urandom_range((pred_max_len < 6) ? int'(pred_max_len) : 6, 0);
    send_byte(len[7:0]);
    if (len <= pred_max_len) begin
      for (i = 0; i < len; i++) send_byte(8'($urandom_range(255)));
    end
  endtask

  // Four phases of random traffic, each with its own registers and idling
  task automatic test_random_traffic();
    logic [7:0] s, g, o;
    int target;
    int p;
    for (p = 0; p < 4; p++) begin
      case (p)
        0: begin
          idle_pct = 0;  stall_pct = 0;
          write_codes(8'h00, 8'hFF, 8'($urandom_range(254, 1)),
                      cfc_pkg::MAX_PARAM_LEN_RST);
        end
        1: begin
          idle_pct = 49; stall_pct = 0;
          draw_codes(s, g, o);
          write_codes(s, g, o, cfc_pkg::PLEN_W'($urandom_range(60, 1)));
        end
        2: begin
          idle_pct = 0;  stall_pct = 49;
          write_codes(cfc_pkg::SET_CODE_RST, cfc_pkg::GET_CODE_RST,
                      cfc_pkg::SET_ONCE_CODE_RST, cfc_pkg::MAX_PARAM_LEN_RST);
        end
        default: begin
          idle_pct = 12; stall_pct = 12;
          draw_codes(s, g, o);
          write_codes(s, g, o, cfc_pkg::PLEN_W'($urandom_range(60)));
        end
      endcase
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        send_random_frame();
        // Hold off the sender once until the output side has caught up
        if (p == 1 && items_sent >= target - PHASE_ITEMS / 2 && target > 0) begin
          wait_frames_drained();
          target = -target;
        end
        if (target < 0 && items_sent >= -target) break;
      end
      wait_frames_drained();
    end
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  initial begin
    foreach (frame_buf[i]) frame_buf[i] = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_length_limit();
    test_equal_codes();
    test_random_traffic();
    wait_frames_drained();
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/cfc_pkg.sv
sv/cfc_ctrl.sv
sv/cfc_datapath.sv
sv/command_frame_collector.sv
tb/sv/tb_top.sv
